[src/station_command_frame_parser_core_assert.svh]
// Assertion macros used by the station command frame parser checker
`ifndef STATION_COMMAND_FRAME_PARSER_CORE_ASSERT_SVH
`define STATION_COMMAND_FRAME_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, ignored while reset is high
`define SCFP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is high
`define SCFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset
`define SCFP_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/scfp_pkg.sv]
// Package: codes, constants and types of the station command frame parser
package scfp_pkg;

  localparam logic [7:0] HDR_BYTE      = 8'h24;
  localparam logic [7:0] TRAIL_1       = 8'hAA;
  localparam logic [7:0] TRAIL_2       = 8'h55;
  localparam logic [7:0] CMD_BOOT      = 8'h42;
  localparam logic [7:0] CMD_RESET     = 8'h56;
  localparam logic [7:0] STATION_RESET = 8'h01;

  localparam logic [3:0] IND_NONE  = 4'h0;
  localparam logic [3:0] IND_BOOT  = 4'hB;
  localparam logic [3:0] IND_RESET = 4'hA;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_BOOT  = 2'd1;
  localparam logic [1:0] ACT_RESET = 2'd2;

  localparam logic [2:0] PH_WAIT    = 3'd0;
  localparam logic [2:0] PH_STATION = 3'd1;
  localparam logic [2:0] PH_RSVD    = 3'd2;
  localparam logic [2:0] PH_LEN     = 3'd3;
  localparam logic [2:0] PH_DATA    = 3'd4;
  localparam logic [2:0] PH_TR1     = 3'd5;
  localparam logic [2:0] PH_TR2     = 3'd6;

  typedef struct packed {
    logic [2:0] phase;
    logic [7:0] bytes_left;
    logic [7:0] frame_len;
    logic [7:0] first_payload;
    logic       first_trailer_ok;
  } parse_state_t;

  typedef struct packed {
    logic       frame_good;
    logic [7:0] payload_length;
    logic [1:0] action;
    logic [3:0] indicator;
  } result_t;

endpackage

[src/scfp_rx_if.sv]
// Interface: received byte channel
interface scfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

[src/scfp_res_if.sv]
// Interface: frame result channel
interface scfp_res_if;
  logic       valid;
  logic       ready;
  logic       frame_good;
  logic [7:0] payload_length;
  logic [1:0] action;
  logic [3:0] indicator;

  modport source (output valid, output frame_good, output payload_length,
                  output action, output indicator, input ready);
  modport sink   (input valid, input frame_good, input payload_length,
                  input action, input indicator, output ready);
endinterface

[src/scfp_step.sv]
// Module: next-state and result rule of the frame parser for one byte
module scfp_step
  import scfp_pkg::*;
(
  input  parse_state_t state,
  input  logic [7:0]   rx_byte,
  input  logic [7:0]   station_id,
  output parse_state_t state_next,
  output logic         res_valid,
  output result_t      res
);

  logic       good;
  logic [7:0] left_dec;

  assign left_dec = state.bytes_left - 8'd1;
  assign good     = state.first_trailer_ok && (rx_byte == TRAIL_2);

  always_comb begin
    state_next         = state;
    res_valid          = 1'b0;
    res.frame_good     = good;
    res.payload_length = state.frame_len;
    res.action         = ACT_NONE;
    res.indicator      = IND_NONE;
    unique case (state.phase)
      PH_STATION: begin
        state_next.phase = (rx_byte == station_id) ? PH_RSVD : PH_WAIT;
      end
      PH_RSVD: begin
        state_next.phase = PH_LEN;
      end
      PH_LEN: begin
        state_next.frame_len     = rx_byte;
        state_next.bytes_left    = rx_byte;
        state_next.first_payload = 8'd0;
        state_next.phase         = (rx_byte == 8'd0) ? PH_TR1 : PH_DATA;
      end
      PH_DATA: begin
        // keep only the first data byte
        if (state.bytes_left == state.frame_len) begin
          state_next.first_payload = rx_byte;
        end
        state_next.bytes_left = left_dec;
        if (left_dec == 8'd0) begin
          state_next.phase = PH_TR1;
        end
      end
      PH_TR1: begin
        state_next.first_trailer_ok = (rx_byte == TRAIL_1);
        state_next.phase            = PH_TR2;
      end
      PH_TR2: begin
        res_valid        = 1'b1;
        state_next.phase = PH_WAIT;
        if (good && state.first_payload == CMD_BOOT) begin
          res.action    = ACT_BOOT;
          res.indicator = IND_BOOT;
        end else if (good && state.first_payload == CMD_RESET) begin
          res.action    = ACT_RESET;
          res.indicator = IND_RESET;
        end
      end
      default: begin
        // waiting for header, unused codes included
        state_next.phase = (rx_byte == HDR_BYTE) ? PH_STATION : PH_WAIT;
      end
    endcase
  end

endmodule

[src/station_command_frame_parser_core.sv]
// Top level: station command frame parser core
//
// Usage
//   rx  : one received serial byte per request (valid/ready, sink side).
//   res : one result per finished frame (valid/ready, source side):
//         frame_good, payload_length, action, indicator.
//   cfg : cfg_wr_en/cfg_wr_data write station_id; write it
//         only while the parser is idle.
// Frames are '$', station, reserved, length, length data bytes, 0xAA, 0x55.
// A frame for another station is dropped; bytes outside a frame are ignored.
// Only the second trailer byte produces a result request.
// Throughput: one byte per clock while no result is held back, set by the
//   combinational next-state rule between input and result registers.
// Path: an accepted byte waits in the input register while it is parsed;
//   its result is then loaded into the result register, which drives res.
// Reset: rst (synchronous, active high) clears both valid flags, returns
//   the parser to waiting for '$' and loads station_id with 1.
// Stall: while res holds an untaken result, a byte that would produce a
//   further result waits in the input register; other bytes keep flowing.
module station_command_frame_parser_core
  import scfp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [7:0]   cfg_wr_data,
  scfp_rx_if.sink      rx,
  scfp_res_if.source   res
);

  // configuration
  logic [7:0] station_id;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;

  // parser state
  parse_state_t state;
  parse_state_t state_next;

  // result register
  logic    out_valid;
  result_t out_res;

  // step outputs and handshake
  logic    step_res_valid;
  result_t step_res;
  logic    out_free;
  logic    in_advance;

  scfp_step u_step (
    .state      (state),
    .rx_byte    (in_byte),
    .station_id (station_id),
    .state_next (state_next),
    .res_valid  (step_res_valid),
    .res        (step_res)
  );

  // result register can take a new request when empty or being drained
  assign out_free   = !out_valid || res.ready;
  // advance the held byte unless it produces a result with nowhere to go
  assign in_advance = in_valid && (!step_res_valid || out_free);
  assign rx.ready   = !in_valid || in_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      station_id <= STATION_RESET;
    end else if (cfg_wr_en) begin
      station_id <= cfg_wr_data;
    end
  end

  // capture incoming byte
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  // update parser state once per consumed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase: PH_WAIT, bytes_left: 8'd0, frame_len: 8'd0,
                 first_payload: 8'd0, first_trailer_ok: 1'b0};
    end else if (in_advance) begin
      state <= state_next;
    end
  end

  // result register: load on a result, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_advance && step_res_valid) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_advance && step_res_valid) begin
      out_res <= step_res;
    end
  end

  assign res.valid          = out_valid;
  assign res.frame_good     = out_res.frame_good;
  assign res.payload_length = out_res.payload_length;
  assign res.action         = out_res.action;
  assign res.indicator      = out_res.indicator;

endmodule

[src/scfp_checker.sv]
// Checker: port-level properties of the station command frame parser
`include "station_command_frame_parser_core_assert.svh"

module scfp_checker
  import scfp_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic       frame_good,
  input logic [7:0] payload_length,
  input logic [1:0] action,
  input logic [3:0] indicator
);

  `SCFP_ASSERT_NEXT_ALWAYS(a_reset_clears_result, clk, rst, !res_valid, "result valid after reset")

  `SCFP_ASSERT_NEXT(a_stall_holds_result, clk, rst, res_valid && !res_ready, res_valid && $stable({frame_good, payload_length, action, indicator}), "stalled result changed")

  `SCFP_ASSERT_IMPLY(a_action_needs_good, clk, rst, res_valid && action != ACT_NONE, frame_good, "action on a bad frame")

  `SCFP_ASSERT_IMPLY(a_indicator_matches, clk, rst, res_valid, (action == ACT_NONE && indicator == IND_NONE) || (action == ACT_BOOT && indicator == IND_BOOT) || (action == ACT_RESET && indicator == IND_RESET), "indicator does not match action")

endmodule

bind station_command_frame_parser_core scfp_checker u_scfp_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .frame_good     (res.frame_good),
  .payload_length (res.payload_length),
  .action         (res.action),
  .indicator      (res.indicator)
);

[verif/station_command_frame_parser_core_test.sv]
// Testbench for the station command frame parser core: random framed traffic, checked per result
module station_command_frame_parser_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import scfp_pkg::*;

  // Stop the run after this many cycles in a row with no request taken on either side.
  localparam int STALL_LIMIT = 5000;
  // Let the receiver refuse results for this many cycles once, in the last phase.
  localparam int HOLD_CYCLES = 400;

  // Track the parser state, predict each frame result, and check the results as they arrive.
  class frame_result_board;
    logic [7:0] station_id;
    logic [2:0] phase;
    logic [7:0] bytes_left;
    logic [7:0] frame_len;
    logic [7:0] first_payload;
    logic       trailer_head_ok;
    result_t    expected_q[$];
    int         errors;

    function new();
      station_id      = STATION_RESET;
      phase           = PH_WAIT;
      bytes_left      = '0;
      frame_len       = '0;
      first_payload   = '0;
      trailer_head_ok = 1'b0;
      errors          = 0;
    endfunction

    // Advance the parser by one received byte; queue a result after the second trailer byte.
    function void note_request(logic [7:0] rx);
      result_t r;
      case (phase)
        PH_STATION: phase = (rx == station_id) ? PH_RSVD : PH_WAIT;
        PH_RSVD:    phase = PH_LEN;
        PH_LEN: begin
          frame_len     = rx;
          bytes_left    = rx;
          first_payload = '0;
          phase         = (rx == 8'd0) ? PH_TR1 : PH_DATA;
        end
        PH_DATA: begin
          if (bytes_left == frame_len) first_payload = rx;
          bytes_left = bytes_left - 8'd1;
          if (bytes_left == 8'd0) phase = PH_TR1;
        end
        PH_TR1: begin
          trailer_head_ok = (rx == TRAIL_1);
          phase           = PH_TR2;
        end
        PH_TR2: begin
          r.frame_good     = trailer_head_ok && (rx == TRAIL_2);
          r.payload_length = frame_len;
          r.action         = ACT_NONE;
          r.indicator      = IND_NONE;
          if (r.frame_good && first_payload == CMD_BOOT) begin
            r.action    = ACT_BOOT;
            r.indicator = IND_BOOT;
          end else if (r.frame_good && first_payload == CMD_RESET) begin
            r.action    = ACT_RESET;
            r.indicator = IND_RESET;
          end
          expected_q.push_back(r);
          phase = PH_WAIT;
        end
        default: phase = (rx == HDR_BYTE) ? PH_STATION : PH_WAIT;
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("result with no frame pending: good %0d len %0d action %0d indicator %0d",
               got.frame_good, got.payload_length, got.action, got.indicator);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.frame_good !== want.frame_good) begin
        $error("frame_good: expected %0d, got %0d", want.frame_good, got.frame_good);
        errors++;
      end
      if (got.payload_length !== want.payload_length) begin
        $error("payload_length: expected %0d, got %0d", want.payload_length, got.payload_length);
        errors++;
      end
      if (got.action !== want.action) begin
        $error("action: expected %0d, got %0d", want.action, got.action);
        errors++;
      end
      if (got.indicator !== want.indicator) begin
        $error("indicator: expected %0d, got %0d", want.indicator, got.indicator);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  scfp_rx_if  rx_ch ();
  scfp_res_if res_ch ();

  station_command_frame_parser_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .rx          (rx_ch.sink),
    .res         (res_ch.source)
  );

  frame_result_board board = new();

  // Idle rates in percent; the sender reads its rate before each byte, the receiver whenever it is not holding off.
  int   src_idle_pct  = 0;
  int   sink_idle_pct = 0;
  // Raised once by the stimulus; the receiver process owns the countdown itself.
  logic start_hold    = 1'b0;
  int   bytes_sent    = 0;
  int   stall_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: take results at the current idle rate, or hold off for one long stretch
  // so the parser backs up and stalls its input.
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (start_hold && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Monitor: sample both channels and the register port at the clock edge,
  // check results before noting the new byte, and watch for a hang.
  always @(posedge clk) begin
    result_t got;
    bit      moved;
    if (!rst) begin
      moved = 1'b0;
      if (cfg_wr_en) board.station_id = cfg_wr_data;
      if (res_ch.valid && res_ch.ready) begin
        got.frame_good     = res_ch.frame_good;
        got.payload_length = res_ch.payload_length;
        got.action         = res_ch.action;
        got.indicator      = res_ch.indicator;
        board.check_result(got);
        moved = 1'b1;
      end
      if (rx_ch.valid && rx_ch.ready) begin
        board.note_request(rx_ch.rx_byte);
        moved = 1'b1;
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Offer one byte, after a random gap at the current idle rate; hold it until taken.
  // Leave valid high on return so back-to-back bytes follow with no gap in valid.
  task automatic send_byte(input logic [7:0] value);
    while ($urandom_range(99) < src_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= value;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Drain the parser, then write station_id while no byte is in flight.
  task automatic write_station(input logic [7:0] value);
    rx_ch.valid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Emit one slice of traffic: mostly well-formed frames for this station with random
  // content, plus loose noise, frames for other stations and bad trailers.
  // A non-negative len_force forces a frame for this station and fixes its length.
  task automatic send_frame(input int len_force);
    int         kind;
    int         pick;
    int         n;
    logic [7:0] len;
    logic [7:0] tr_a;
    logic [7:0] tr_b;
    kind = (len_force >= 0) ? 99 : $urandom_range(99);
    if (kind < 8) begin
      // Loose bytes between frames; a stray header starts a frame of its own.
      n = $urandom_range(1, 3);
      repeat (n) send_byte(8'($urandom_range(255)));
    end else if (kind < 16) begin
      // Wrong station: the parser drops back to waiting after the station byte.
      send_byte(HDR_BYTE);
      send_byte(board.station_id ^ 8'($urandom_range(1, 255)));
      n = $urandom_range(0, 4);
      repeat (n) send_byte(8'($urandom_range(255)));
    end else begin
      send_byte(HDR_BYTE);
      send_byte(board.station_id);
      send_byte(8'($urandom_range(255)));
      if (len_force >= 0) begin
        len = 8'(len_force);
      end else begin
        pick = $urandom_range(99);
        if (pick < 10)      len = 8'd0;
        else if (pick < 11) len = 8'hFF;
        else                len = 8'($urandom_range(1, 6));
      end
      send_byte(len);
      if (len != 8'd0) begin
        pick = $urandom_range(9);
        if (pick < 3)      send_byte(CMD_BOOT);
        else if (pick < 6) send_byte(CMD_RESET);
        else               send_byte(8'($urandom_range(255)));
        repeat (int'(len) - 1) send_byte(8'($urandom_range(255)));
      end
      // Break the trailer now and then: either byte wrong, or both.
      tr_a = TRAIL_1;
      tr_b = TRAIL_2;
      case ($urandom_range(9))
        0: tr_a = 8'($urandom_range(255));
        1: tr_b = 8'($urandom_range(255));
        2: begin
          tr_a = 8'($urandom_range(255));
          tr_b = 8'($urandom_range(255));
        end
        default: ;
      endcase
      send_byte(tr_a);
      send_byte(tr_b);
    end
  endtask

  // Run traffic until count more bytes have gone in; start the long receiver hold
  // once hold_after bytes of this stretch are in, if hold_after is non-negative.
  task automatic run_traffic(input int count, input int hold_after);
    int first;
    first = bytes_sent;
    while (bytes_sent - first < count) begin
      if (hold_after >= 0 && bytes_sent - first >= hold_after) start_hold = 1'b1;
      send_frame(-1);
    end
  endtask

  initial begin
    logic [7:0] opening[$];
    rst           <= 1'b1;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= '0;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed bytes under the reset station number: ignored noise at both extremes,
    // a boot frame, a zero-length frame, a header taken as a mismatched station byte,
    // and a reset command with a broken second trailer byte.
    opening = '{8'h00, 8'hFF,
                HDR_BYTE, STATION_RESET, 8'h00, 8'h01, CMD_BOOT, TRAIL_1, TRAIL_2,
                HDR_BYTE, STATION_RESET, 8'hFF, 8'h00, TRAIL_1, TRAIL_2,
                HDR_BYTE, HDR_BYTE,
                HDR_BYTE, STATION_RESET, 8'h5A, 8'h02, CMD_RESET, 8'h00, TRAIL_1, 8'h54};
    foreach (opening[i]) send_byte(opening[i]);

    // Sender mostly busy, receiver mostly idle; station 0.
    write_station(8'h00);
    src_idle_pct  = 16;
    sink_idle_pct = 88;
    run_traffic(400, -1);

    // Sender mostly idle, receiver mostly busy; station 255.
    write_station(8'hFF);
    src_idle_pct  = 88;
    sink_idle_pct = 16;
    run_traffic(400, -1);

    // No idling at all on a random station; one maximum-length frame, then the long hold.
    write_station(8'($urandom_range(255)));
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    send_frame(255);
    run_traffic(300, 100);

    // Drain every pending result, then give the result register time to settle.
    rx_ch.valid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
